// File: src/serle_pkg.sv
`timescale 1ns / 1ps

package serle_pkg;

   localparam logic [14:0] STRIDE_MASK = 15'h7fff;

   typedef enum logic [3:0] {
      PH_HDR_ESC   = 4'd0,
      PH_HDR_FILL  = 4'd1,
      PH_HDR_HI    = 4'd2,
      PH_HDR_LO    = 4'd3,
      PH_IDLE      = 4'd4,
      PH_AFTER_ESC = 4'd5,
      PH_C0_COUNT  = 4'd6,
      PH_C0_VALUE  = 4'd7,
      PH_C1_HI     = 4'd8,
      PH_C1_LO     = 4'd9,
      PH_C1_VALUE  = 4'd10,
      PH_C2_HI     = 4'd11,
      PH_C2_LO     = 4'd12,
      PH_K_VALUE   = 4'd13,
      PH_RUN       = 4'd14,
      PH_DONE      = 4'd15
   } phase_type;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  escape_code;
      logic [14:0] stride;
      logic [15:0] column;
      logic [15:0] position;
      logic [15:0] columns_left;
      logic [15:0] run_left;
      logic [7:0]  run_value;
      logic        run_is_skip;
   } state_type;

   // outcome of one screen position step
   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_address;
      logic [7:0]  write_value;
      logic [15:0] position;
      logic [15:0] column;
      logic [15:0] columns_left;
      logic        done;
   } advance_type;

   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_address;
      logic [7:0]  write_value;
      logic        fill_valid;
      logic [7:0]  fill_value;
      logic        run_pending;
      logic        finished;
      logic        protocol_error;
   } result_type;

endpackage

// File: src/strided_escape_rle_decoder_unit.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_action, req_stream_byte
// rsp     | out       | rsp_valid / rsp_ready | write, fill, run_pending, finished, error
//
// one result per transfer, one transfer per cycle sustained while rsp_ready stays high
// a req item passes through the input register and then the result register before
// rsp_valid rises; a stalled rsp side can hold it in the input register
// the decode state is updated when an item moves from the input register into
// the result register, so the next item to be decoded already sees it
// synchronous active-high reset returns to the header phase with decode state and valid flags cleared
// a stalled rsp side holds the result register; req_ready drops only when both
// the input register and the result register are full

module strided_escape_rle_decoder_unit #(
   parameter int SCREEN_BYTES = 32000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_valid,
   output logic [15:0] rsp_write_address,
   output logic [7:0]  rsp_write_value,
   output logic        rsp_fill_valid,
   output logic [7:0]  rsp_fill_value,
   output logic        rsp_run_pending,
   output logic        rsp_finished,
   output logic        rsp_protocol_error
);

   // input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;

   // decode state and result register
   serle_pkg::state_type  state_ff;
   serle_pkg::state_type  state_in;
   serle_pkg::result_type result_ff;
   serle_pkg::result_type result_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;

   logic req_xfer;
   logic decode_go;

   // the item in the input register moves on when the result register frees up
   assign decode_go = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || decode_go;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !decode_go);
   assign out_valid_in = decode_go || (out_valid_ff && !rsp_ready);

   serle_decode #(
      .SCREEN_BYTES(SCREEN_BYTES)
   ) u_decode (
      .cur        (state_ff),
      .action     (in_action_ff),
      .stream_byte(in_byte_ff),
      .nxt        (state_in),
      .res        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: serle_pkg::PH_HDR_ESC, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (decode_go) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_stream_byte;
      end
      if (decode_go) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_write_valid    = result_ff.write_valid;
   assign rsp_write_address  = result_ff.write_address;
   assign rsp_write_value    = result_ff.write_value;
   assign rsp_fill_valid     = result_ff.fill_valid;
   assign rsp_fill_value     = result_ff.fill_value;
   assign rsp_run_pending    = result_ff.run_pending;
   assign rsp_finished       = result_ff.finished;
   assign rsp_protocol_error = result_ff.protocol_error;

endmodule

// File: src/serle_advance.sv
`timescale 1ns / 1ps

module serle_advance #(
   parameter int SCREEN_BYTES = 32000
) (
   input  serle_pkg::state_type   cur,
   input  logic                   wr,
   input  logic [7:0]             value,
   output serle_pkg::advance_type adv
);

   localparam logic [16:0] SCREEN_LIMIT = 17'(SCREEN_BYTES);

   logic [16:0] sum;
   logic [15:0] next_pos;
   logic [15:0] next_col;
   logic        wrap;

   assign sum      = {1'b0, cur.position} + {2'b00, cur.stride};
   assign next_pos = sum[15:0];
   assign wrap     = {1'b0, next_pos} >= SCREEN_LIMIT;
   assign next_col = cur.column + 16'd1;

   always_comb begin
      adv.write_valid   = wr && ({1'b0, cur.position} < SCREEN_LIMIT);
      adv.write_address = adv.write_valid ? cur.position : 16'd0;
      adv.write_value   = adv.write_valid ? value : 8'd0;
      adv.position      = next_pos;
      adv.column        = cur.column;
      adv.columns_left  = cur.columns_left;
      adv.done          = 1'b0;
      if (wrap) begin
         // top of the next column
         adv.column   = next_col;
         adv.position = next_col;
         if (cur.columns_left == 16'd0) begin
            adv.done = 1'b1;
         end else begin
            adv.columns_left = cur.columns_left - 16'd1;
         end
      end
   end

endmodule

// File: src/serle_decode.sv
`timescale 1ns / 1ps

module serle_decode #(
   parameter int SCREEN_BYTES = 32000
) (
   input  serle_pkg::state_type  cur,
   input  logic                  action,
   input  logic [7:0]            stream_byte,
   output serle_pkg::state_type  nxt,
   output serle_pkg::result_type res
);

   serle_pkg::advance_type adv;
   logic                   adv_wr;
   logic [7:0]             adv_value;
   logic                   use_adv;
   logic [15:0]            lo_stride;

   assign adv_wr    = (action == serle_pkg::ACT_STEP) ? !cur.run_is_skip : 1'b1;
   assign adv_value = (action == serle_pkg::ACT_STEP) ? cur.run_value : stream_byte;
   assign lo_stride = {1'b0, cur.stride | {7'd0, stream_byte}};

   serle_advance #(
      .SCREEN_BYTES(SCREEN_BYTES)
   ) u_advance (
      .cur  (cur),
      .wr   (adv_wr),
      .value(adv_value),
      .adv  (adv)
   );

   always_comb begin
      nxt     = cur;
      use_adv = 1'b0;
      res     = '0;

      if (action == serle_pkg::ACT_STEP) begin
         if (cur.phase != serle_pkg::PH_RUN) begin
            res.protocol_error = 1'b1;
         end else begin
            use_adv = 1'b1;
            if (adv.done) begin
               nxt.phase = serle_pkg::PH_DONE;
            end else if (cur.run_left == 16'd0) begin
               nxt.phase = serle_pkg::PH_IDLE;
            end else begin
               nxt.run_left = cur.run_left - 16'd1;
            end
         end
      end else begin
         case (cur.phase)
            serle_pkg::PH_HDR_ESC: begin
               nxt.escape_code = stream_byte;
               nxt.phase       = serle_pkg::PH_HDR_FILL;
            end
            serle_pkg::PH_HDR_FILL: begin
               res.fill_valid = 1'b1;
               res.fill_value = stream_byte;
               nxt.phase      = serle_pkg::PH_HDR_HI;
            end
            serle_pkg::PH_HDR_HI: begin
               nxt.stride = {stream_byte[6:0], 8'd0} & serle_pkg::STRIDE_MASK;
               nxt.phase  = serle_pkg::PH_HDR_LO;
            end
            serle_pkg::PH_HDR_LO: begin
               nxt.stride   = lo_stride[14:0] & serle_pkg::STRIDE_MASK;
               nxt.column   = 16'd0;
               nxt.position = 16'd0;
               if (lo_stride == 16'd0) begin
                  nxt.phase = serle_pkg::PH_DONE;
               end else begin
                  nxt.columns_left = lo_stride - 16'd1;
                  nxt.phase        = serle_pkg::PH_IDLE;
               end
            end
            serle_pkg::PH_IDLE: begin
               if (stream_byte == cur.escape_code) begin
                  nxt.phase = serle_pkg::PH_AFTER_ESC;
               end else begin
                  use_adv = 1'b1;
                  if (adv.done) begin
                     nxt.phase = serle_pkg::PH_DONE;
                  end
               end
            end
            serle_pkg::PH_AFTER_ESC: begin
               if (stream_byte == cur.escape_code) begin
                  use_adv   = 1'b1;
                  nxt.phase = adv.done ? serle_pkg::PH_DONE : serle_pkg::PH_IDLE;
               end else if (stream_byte == 8'd0) begin
                  nxt.phase = serle_pkg::PH_C0_COUNT;
               end else if (stream_byte == 8'd1) begin
                  nxt.phase = serle_pkg::PH_C1_HI;
               end else if (stream_byte == 8'd2) begin
                  nxt.phase = serle_pkg::PH_C2_HI;
               end else begin
                  nxt.run_left = {8'd0, stream_byte};
                  nxt.phase    = serle_pkg::PH_K_VALUE;
               end
            end
            serle_pkg::PH_C0_COUNT: begin
               nxt.run_left = {8'd0, stream_byte};
               nxt.phase    = serle_pkg::PH_C0_VALUE;
            end
            serle_pkg::PH_C0_VALUE, serle_pkg::PH_C1_VALUE, serle_pkg::PH_K_VALUE: begin
               nxt.run_value   = stream_byte;
               nxt.run_is_skip = 1'b0;
               nxt.phase       = serle_pkg::PH_RUN;
            end
            serle_pkg::PH_C1_HI: begin
               nxt.run_left = {stream_byte, 8'd0};
               nxt.phase    = serle_pkg::PH_C1_LO;
            end
            serle_pkg::PH_C1_LO: begin
               nxt.run_left = {cur.run_left[15:8], stream_byte};
               nxt.phase    = serle_pkg::PH_C1_VALUE;
            end
            serle_pkg::PH_C2_HI: begin
               if (stream_byte == 8'd0) begin
                  nxt.phase = serle_pkg::PH_DONE;
               end else begin
                  nxt.run_left = {stream_byte, 8'd0};
                  nxt.phase    = serle_pkg::PH_C2_LO;
               end
            end
            serle_pkg::PH_C2_LO: begin
               nxt.run_left    = {cur.run_left[15:8], stream_byte};
               nxt.run_value   = 8'd0;
               nxt.run_is_skip = 1'b1;
               nxt.phase       = serle_pkg::PH_RUN;
            end
            serle_pkg::PH_RUN: begin
               res.protocol_error = 1'b1;
            end
            default: begin
               // after the end code bytes are dropped
            end
         endcase
      end

      if (use_adv) begin
         res.write_valid   = adv.write_valid;
         res.write_address = adv.write_address;
         res.write_value   = adv.write_value;
         nxt.position      = adv.position;
         nxt.column        = adv.column;
         nxt.columns_left  = adv.columns_left;
      end

      res.run_pending = (nxt.phase == serle_pkg::PH_RUN);
      res.finished    = (nxt.phase == serle_pkg::PH_DONE);
   end

endmodule

// File: src/serle_checker.sv
`timescale 1ns / 1ps

module serle_checker #(
   parameter int SCREEN_BYTES = 32000
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_action,
   input logic [7:0]  req_stream_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_write_valid,
   input logic [15:0] rsp_write_address,
   input logic [7:0]  rsp_write_value,
   input logic        rsp_fill_valid,
   input logic [7:0]  rsp_fill_value,
   input logic        rsp_run_pending,
   input logic        rsp_finished,
   input logic        rsp_protocol_error
);

   localparam logic [16:0] SCREEN_LIMIT = 17'(SCREEN_BYTES);

   // writes stay on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> {1'b0, rsp_write_address} < SCREEN_LIMIT)
      else $error("write outside screen");

   // a pending run and the end never coexist
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_run_pending && rsp_finished))
      else $error("run pending after end");

   // a rejected item writes nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_protocol_error |-> !rsp_write_valid && !rsp_fill_valid)
      else $error("ignored item produced a write");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_address)
         && $stable(rsp_write_valid) && $stable(rsp_write_value)
         && $stable(rsp_fill_valid) && $stable(rsp_fill_value)
         && $stable(rsp_run_pending) && $stable(rsp_finished)
         && $stable(rsp_protocol_error))
      else $error("stalled result changed");

   // a waiting req transfer holds its payload
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_action)
         && $stable(req_stream_byte))
      else $error("waiting request changed");

endmodule

bind strided_escape_rle_decoder_unit serle_checker #(
   .SCREEN_BYTES(SCREEN_BYTES)
) u_serle_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps

// testbench for the strided escape rle decoder: a header picked at random per seed,
// a short directed table, random escape sequences, the end code and trailing items,
// each item checked against a local decode of the stream
module testbench;

   localparam int SCREEN_BYTES = 32000;
   localparam int RANDOM_END = 690;

   // second byte of an escape sequence, and the skip count high byte that marks the end
   localparam logic [7:0] CODE_BYTE_RUN = 8'h00;
   localparam logic [7:0] CODE_WORD_RUN = 8'h01;
   localparam logic [7:0] CODE_SKIP     = 8'h02;
   localparam logic [7:0] SKIP_END_HI   = 8'h00;

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic                  act;
      logic [7:0]            data;
      logic                  typed;
      logic                  drain;
      serle_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [7:0]  req_stream_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_write_valid;
   logic [15:0] rsp_write_address;
   logic [7:0]  rsp_write_value;
   logic        rsp_fill_valid;
   logic [7:0]  rsp_fill_value;
   logic        rsp_run_pending;
   logic        rsp_finished;
   logic        rsp_protocol_error;

   // decoder state as predicted from the accepted stream
   serle_pkg::phase_type dec_phase = serle_pkg::PH_HDR_ESC;
   logic [7:0]  esc_byte = '0;
   logic [14:0] col_stride = '0;
   logic [15:0] cur_column = '0;
   logic [15:0] cur_position = '0;
   logic [15:0] wraps_left = '0;
   logic [15:0] run_count = '0;
   logic [7:0]  run_byte = '0;
   logic        run_skips = 1'b0;

   serle_pkg::result_type decoded_q[$];
   serle_pkg::result_type want_result;
   stim_row_type          stim_rows[$];
   int          accepted_items = 0;
   int          mismatch_count = 0;
   int          send_idle_pct;
   int          rsp_stall_pct;

   strided_escape_rle_decoder_unit #(
      .SCREEN_BYTES(SCREEN_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_stream_byte(req_stream_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_write_valid(rsp_write_valid),
      .rsp_write_address(rsp_write_address),
      .rsp_write_value(rsp_write_value),
      .rsp_fill_valid(rsp_fill_valid),
      .rsp_fill_value(rsp_fill_value),
      .rsp_run_pending(rsp_run_pending),
      .rsp_finished(rsp_finished),
      .rsp_protocol_error(rsp_protocol_error)
   );

   always #1 clock = ~clock;

   // one screen position: write if asked and on screen, then step down the column,
   // wrapping to the top of the next column past the screen end
   function automatic void screen_advance(input logic wr, input logic [7:0] v,
                                          inout serle_pkg::result_type r);
      if (wr && cur_position < SCREEN_BYTES) begin
         r.write_valid = 1'b1;
         r.write_address = cur_position;
         r.write_value = v;
      end
      cur_position = cur_position + 16'(col_stride);
      if (cur_position >= SCREEN_BYTES) begin
         cur_column = cur_column + 16'd1;
         cur_position = cur_column;
         // out of columns: decoding stops here, any pending run is dropped
         if (wraps_left == '0) dec_phase = serle_pkg::PH_DONE;
         else wraps_left = wraps_left - 16'd1;
      end
   endfunction

   // expected result of one accepted item, advancing the predicted state
   function automatic serle_pkg::result_type decode_item(input logic act,
                                                         input logic [7:0] b);
      serle_pkg::result_type r;
      r = '0;
      if (act == serle_pkg::ACT_STEP) begin
         if (dec_phase != serle_pkg::PH_RUN) begin
            r.protocol_error = 1'b1;
         end else begin
            screen_advance(!run_skips, run_byte, r);
            if (dec_phase != serle_pkg::PH_DONE) begin
               if (run_count == '0) dec_phase = serle_pkg::PH_IDLE;
               else run_count = run_count - 16'd1;
            end
         end
      end else begin
         case (dec_phase)
            serle_pkg::PH_HDR_ESC: begin
               esc_byte = b;
               dec_phase = serle_pkg::PH_HDR_FILL;
            end
            serle_pkg::PH_HDR_FILL: begin
               r.fill_valid = 1'b1;
               r.fill_value = b;
               dec_phase = serle_pkg::PH_HDR_HI;
            end
            serle_pkg::PH_HDR_HI: begin
               // top bit of the stride is masked off
               col_stride = {b[6:0], 8'h00};
               dec_phase = serle_pkg::PH_HDR_LO;
            end
            serle_pkg::PH_HDR_LO: begin
               col_stride = col_stride | 15'(b);
               cur_column = '0;
               cur_position = '0;
               if (col_stride == '0) begin
                  dec_phase = serle_pkg::PH_DONE;
               end else begin
                  wraps_left = 16'(col_stride) - 16'd1;
                  dec_phase = serle_pkg::PH_IDLE;
               end
            end
            serle_pkg::PH_IDLE: begin
               if (b == esc_byte) dec_phase = serle_pkg::PH_AFTER_ESC;
               else screen_advance(1'b1, b, r);
            end
            serle_pkg::PH_AFTER_ESC: begin
               // a doubled escape wins over the codes
               if (b == esc_byte) begin
                  screen_advance(1'b1, b, r);
                  if (dec_phase != serle_pkg::PH_DONE) dec_phase = serle_pkg::PH_IDLE;
               end else if (b == CODE_BYTE_RUN) begin
                  dec_phase = serle_pkg::PH_C0_COUNT;
               end else if (b == CODE_WORD_RUN) begin
                  dec_phase = serle_pkg::PH_C1_HI;
               end else if (b == CODE_SKIP) begin
                  dec_phase = serle_pkg::PH_C2_HI;
               end else begin
                  run_count = 16'(b);
                  dec_phase = serle_pkg::PH_K_VALUE;
               end
            end
            serle_pkg::PH_C0_COUNT: begin
               run_count = 16'(b);
               dec_phase = serle_pkg::PH_C0_VALUE;
            end
            serle_pkg::PH_C0_VALUE, serle_pkg::PH_C1_VALUE, serle_pkg::PH_K_VALUE: begin
               run_byte = b;
               run_skips = 1'b0;
               dec_phase = serle_pkg::PH_RUN;
            end
            serle_pkg::PH_C1_HI: begin
               run_count = {b, 8'h00};
               dec_phase = serle_pkg::PH_C1_LO;
            end
            serle_pkg::PH_C1_LO: begin
               run_count = run_count | 16'(b);
               dec_phase = serle_pkg::PH_C1_VALUE;
            end
            serle_pkg::PH_C2_HI: begin
               if (b == SKIP_END_HI) begin
                  dec_phase = serle_pkg::PH_DONE;
               end else begin
                  run_count = {b, 8'h00};
                  dec_phase = serle_pkg::PH_C2_LO;
               end
            end
            serle_pkg::PH_C2_LO: begin
               run_count = run_count | 16'(b);
               run_byte = '0;
               run_skips = 1'b1;
               dec_phase = serle_pkg::PH_RUN;
            end
            serle_pkg::PH_RUN: r.protocol_error = 1'b1;
            default: ;
         endcase
      end
      r.run_pending = (dec_phase == serle_pkg::PH_RUN);
      r.finished = (dec_phase == serle_pkg::PH_DONE);
      return r;
   endfunction

   // present one item, hold it until the transfer, then queue what it should produce
   task automatic send_item(input logic act, input logic [7:0] b, input logic typed,
                            input serle_pkg::result_type want);
      serle_pkg::result_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_stream_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = decode_item(act, b);
      decoded_q.push_back(typed ? want : pred);
      accepted_items++;
      // idling pattern changes; the sender drains the decoder first
      if (accepted_items == 250 || accepted_items == 500) begin
         req_valid <= 1'b0;
         while (decoded_q.size() != 0) @(posedge clock);
         send_idle_pct = (accepted_items == 250) ? 46 : 0;
         rsp_stall_pct = (accepted_items == 250) ? 7 : 0;
      end
   endtask

   task automatic stream_byte(input logic [7:0] b);
      send_item(serle_pkg::ACT_BYTE, b, 1'b0, '0);
   endtask

   task automatic step_item;
      send_item(serle_pkg::ACT_STEP, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // step a pending run or skip to its end, now and then cutting in with a byte
   task automatic finish_run;
      while (dec_phase == serle_pkg::PH_RUN) begin
         if ($urandom_range(0, 49) == 0) stream_byte(8'($urandom_range(0, 255)));
         else step_item;
      end
   endtask

   function automatic void add_row(input logic act, input logic [7:0] data,
                                   input logic drain);
      stim_rows.push_back('{act, data, 1'b0, drain, serle_pkg::result_type'('0)});
   endfunction

   function automatic void add_typed(input logic act, input logic [7:0] data,
                                     input serle_pkg::result_type want);
      stim_rows.push_back('{act, data, 1'b1, 1'b0, want});
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // every result transfer is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            $error("result transfer with nothing expected");
            mismatch_count++;
         end else begin
            want_result = decoded_q.pop_front();
            check_field("write_valid", 16'(want_result.write_valid), 16'(rsp_write_valid));
            check_field("write_address", want_result.write_address, rsp_write_address);
            check_field("write_value", 16'(want_result.write_value), 16'(rsp_write_value));
            check_field("fill_valid", 16'(want_result.fill_valid), 16'(rsp_fill_valid));
            check_field("fill_value", 16'(want_result.fill_value), 16'(rsp_fill_value));
            check_field("run_pending", 16'(want_result.run_pending), 16'(rsp_run_pending));
            check_field("finished", 16'(want_result.finished), 16'(rsp_finished));
            check_field("protocol_error", 16'(want_result.protocol_error),
                        16'(rsp_protocol_error));
         end
      end
   end

   initial begin
      logic [7:0]  hdr_esc, hdr_fill, lit, val, k, lit_lo, k_min;
      logic [14:0] hdr_stride;
      logic        hdr_top;
      int          pick, mode;
      serle_pkg::result_type flag_none, flag_err, flag_fill, flag_lo;

      reset = 1'b1;
      req_valid = 1'b0;
      req_action = serle_pkg::ACT_BYTE;
      req_stream_byte = '0;
      send_idle_pct = 7;
      rsp_stall_pct = 46;

      // one stream per run, so the header is picked per seed
      case ($urandom_range(0, 3))
         0: hdr_esc = 8'h00;
         1: hdr_esc = 8'hff;
         2: hdr_esc = 8'h1b;
         default: hdr_esc = 8'($urandom_range(0, 255));
      endcase
      // the end code needs an escape other than the skip code
      if (hdr_esc == CODE_SKIP) hdr_esc = 8'h1b;
      hdr_fill = 8'($urandom_range(0, 255));
      hdr_top = 1'($urandom_range(0, 1));
      mode = $urandom_range(0, 19);
      if (mode == 0) hdr_stride = '0;
      // wider than the screen: every step wraps, late columns start off screen
      else if (mode < 5) hdr_stride = 15'($urandom_range(32001, 32767));
      else if (mode < 11) hdr_stride = 15'($urandom_range(1, 8));
      else hdr_stride = 15'($urandom_range(64, 1024));

      flag_none = '0;
      flag_err = '0;
      flag_err.protocol_error = 1'b1;
      flag_fill = '0;
      flag_fill.fill_valid = 1'b1;
      flag_fill.fill_value = hdr_fill;
      flag_lo = '0;
      flag_lo.finished = (hdr_stride == '0);

      lit_lo = (hdr_esc == 8'h00) ? 8'h01 : 8'h00;
      k_min = (hdr_esc == 8'h03) ? 8'h04 : 8'h03;

      // header, with steps before it and inside it
      add_typed(serle_pkg::ACT_STEP, 8'h00, flag_err);
      add_typed(serle_pkg::ACT_BYTE, hdr_esc, flag_none);
      add_typed(serle_pkg::ACT_STEP, 8'hff, flag_err);
      add_typed(serle_pkg::ACT_BYTE, hdr_fill, flag_fill);
      add_typed(serle_pkg::ACT_BYTE, {hdr_top, hdr_stride[14:8]}, flag_none);
      add_typed(serle_pkg::ACT_BYTE, hdr_stride[7:0], flag_lo);
      // step with nothing pending, lowest literal, doubled escape
      add_row(serle_pkg::ACT_STEP, 8'h00, 1'b0);
      add_row(serle_pkg::ACT_BYTE, lit_lo, 1'b0);
      add_row(serle_pkg::ACT_BYTE, hdr_esc, 1'b0);
      add_row(serle_pkg::ACT_BYTE, hdr_esc, 1'b0);
      // byte run with a step inside the sequence and a byte while it is pending
      add_row(serle_pkg::ACT_BYTE, hdr_esc, 1'b0);
      add_row(serle_pkg::ACT_STEP, 8'h00, 1'b0);
      add_row(serle_pkg::ACT_BYTE, CODE_BYTE_RUN, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'h02, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'hff, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'h55, 1'b0);
      add_row(serle_pkg::ACT_STEP, 8'h00, 1'b1);
      // word run of two
      add_row(serle_pkg::ACT_BYTE, hdr_esc, 1'b0);
      add_row(serle_pkg::ACT_BYTE, CODE_WORD_RUN, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'h00, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'h01, 1'b0);
      add_row(serle_pkg::ACT_BYTE, lit_lo, 1'b1);
      // shortest counted run, then the shortest skip
      add_row(serle_pkg::ACT_BYTE, hdr_esc, 1'b0);
      add_row(serle_pkg::ACT_BYTE, k_min, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'haa, 1'b1);
      add_row(serle_pkg::ACT_BYTE, hdr_esc, 1'b0);
      add_row(serle_pkg::ACT_BYTE, CODE_SKIP, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'h01, 1'b0);
      add_row(serle_pkg::ACT_BYTE, 8'h00, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         send_item(stim_rows[i].act, stim_rows[i].data, stim_rows[i].typed,
                   stim_rows[i].want);
         if (stim_rows[i].drain) finish_run;
      end

      // random body: mostly well-formed sequences, some broken ones and noise
      while (accepted_items < RANDOM_END && dec_phase != serle_pkg::PH_DONE) begin
         pick = $urandom_range(0, 99);
         lit = 8'($urandom_range(0, 255));
         if (lit == esc_byte) lit = lit ^ 8'h01;
         val = 8'($urandom_range(0, 255));
         if (pick < 35) begin
            stream_byte(lit);
         end else if (pick < 45) begin
            stream_byte(esc_byte);
            stream_byte(esc_byte);
         end else if (pick < 58) begin
            stream_byte(esc_byte);
            stream_byte(CODE_BYTE_RUN);
            stream_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 15)));
            stream_byte(val);
         end else if (pick < 68) begin
            stream_byte(esc_byte);
            stream_byte(CODE_WORD_RUN);
            if ($urandom_range(0, 9) == 0) begin
               stream_byte(8'($urandom_range(1, 3)));
               stream_byte(8'($urandom_range(0, 255)));
            end else begin
               stream_byte(8'h00);
               stream_byte(8'($urandom_range(0, 40)));
            end
            stream_byte(val);
         end else if (pick < 80) begin
            k = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(3, 255))
                                            : 8'($urandom_range(3, 20));
            if (k == esc_byte) k = (k == 8'hff) ? 8'h03 : k + 8'h01;
            stream_byte(esc_byte);
            stream_byte(k);
            stream_byte(val);
         end else if (pick < 82) begin
            stream_byte(esc_byte);
            stream_byte(CODE_SKIP);
            stream_byte(8'h01);
            stream_byte(val);
         end else if (pick < 88) begin
            // escape left open: a step is refused, the next byte reads as a code
            stream_byte(esc_byte);
            step_item;
         end else begin
            send_item(1'($urandom_range(0, 1)), val, 1'b0, '0);
         end
         finish_run;
      end

      // close the stream with the end code, first completing any open sequence
      while (dec_phase != serle_pkg::PH_DONE) begin
         finish_run;
         if (dec_phase == serle_pkg::PH_IDLE) begin
            stream_byte(esc_byte);
            stream_byte(CODE_SKIP);
            stream_byte(SKIP_END_HI);
         end else if (dec_phase != serle_pkg::PH_DONE) begin
            stream_byte(8'h00);
         end
      end

      // after the end: bytes pass silently, steps are refused
      repeat (6) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      while (accepted_items < RANDOM_END) begin
         send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard, far beyond the longest stream and its stalls
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
